// ===== rtl/assert_macros.svh =====
// Assertion helpers used by scan_disk_scheduler.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/sdsch_pkg.sv =====
`timescale 1ns / 1ps

package sdsch_pkg;

  // Field widths.
  localparam int CYL_W  = 16;
  localparam int SIZE_W = 17;
  localparam int MOVE_W = 17;

  // Default request capacity.
  localparam int MAX_REQ_DEF = 32;

  // Disk size after reset and its legal bounds.
  localparam logic [SIZE_W-1:0] DISK_SIZE_RST = 17'd200;
  localparam logic [SIZE_W-1:0] DISK_SIZE_MIN = 17'd2;
  localparam logic [SIZE_W-1:0] DISK_SIZE_MAX = 17'd65536;

  // Input op codes.
  localparam logic OP_HEAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef logic [CYL_W-1:0] cyl_t;

  // Insert command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    cyl_t key;
  } sdsch_ctl_t;

endpackage

// ===== rtl/scan_disk_scheduler.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// SCAN (elevator) disk scheduler. A job is a head-position beat (op 0)
// followed by request beats (op 1); each beat is taken while busy is low,
// and requests are sorted into a chain of MAX_REQUESTS cells as they
// arrive, so back-to-back beats are fine. The beat with last set starts
// scheduling: busy rises, the PREP state finds the split between lower and
// upper requests, then count+3 results come out on consecutive cycles,
// starting from the HEAD state. The emission sequencer reads one cell per
// cycle, which sets that rate. Results are shown for one cycle under
// visit_valid and cannot be stalled; the receiver must take each one.
// Requests past capacity are dropped and flagged in overflow.
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = sdsch_pkg::MAX_REQ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [sdsch_pkg::CYL_W-1:0]   cylinder,
  input  logic                          last,
  input  logic                          disk_size_we,
  input  logic [sdsch_pkg::SIZE_W-1:0]  disk_size_wdata,
  output logic                          visit_valid,
  output logic [sdsch_pkg::CYL_W-1:0]   visit_cylinder,
  output logic [sdsch_pkg::MOVE_W-1:0]  total_movement,
  output logic                          overflow,
  output logic                          last_res
);
  import sdsch_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_HEAD = 7'b0000100,
    S_ASC  = 7'b0001000,
    S_MID  = 7'b0010000,
    S_DESC = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   disk_size;
  cyl_t                head;
  logic [CW-1:0]       count;
  logic                dropped;
  logic [CW-1:0]       lower;
  logic                up_first;
  logic [IW-1:0]       idx;

  logic                accept;
  logic                full;
  logic [SIZE_W-1:0]   size_c;
  cyl_t                top_c;
  cyl_t                head_c;
  cyl_t                rd_val;
  cyl_t                rd_clamp;
  logic [CW-1:0]       lower_next;
  sdsch_ctl_t          ctl;

  cyl_t                cell_val  [MAX_REQUESTS];
  logic                cell_keep [MAX_REQUESTS];
  logic                cell_below[MAX_REQUESTS];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(MAX_REQUESTS));

  // Disk geometry, clamped to the legal range.
  always_comb begin
    if (disk_size < DISK_SIZE_MIN) begin
      size_c = DISK_SIZE_MIN;
    end else if (disk_size > DISK_SIZE_MAX) begin
      size_c = DISK_SIZE_MAX;
    end else begin
      size_c = disk_size;
    end
  end
  assign top_c  = CYL_W'(size_c - SIZE_W'(1));
  assign head_c = (head > top_c) ? top_c : head;

  // Insert command for the cell chain.
  assign ctl = '{ins: accept && (op == OP_REQUEST) && !full, key: cylinder};

  // Chain of sorting cells.
  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    logic occ;
    logic pk;
    cyl_t pv;
    assign occ = (CW'(i) < count);
    if (i == 0) begin : g_first
      assign pk = 1'b1;
      assign pv = cylinder;
    end else begin : g_rest
      assign pk = cell_keep[i-1];
      assign pv = cell_val[i-1];
    end
    sdsch_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .prev_keep (pk),
      .prev_val  (pv),
      .head_c    (head_c),
      .val       (cell_val[i]),
      .keep      (cell_keep[i]),
      .below     (cell_below[i])
    );
  end

  // The lower requests are a prefix; find the first cell that is not below.
  always_comb begin
    lower_next = count;
    for (int i = MAX_REQUESTS - 1; i >= 0; i--) begin
      if (!cell_below[i] && (CW'(i) < count)) begin
        lower_next = CW'(i);
      end
    end
  end

  // Cell read for emission, clamped to the top cylinder.
  assign rd_val   = cell_val[idx];
  assign rd_clamp = (rd_val > top_c) ? top_c : rd_val;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size <= DISK_SIZE_RST;
    end else if (disk_size_we) begin
      disk_size <= disk_size_wdata;
    end
  end

  // Job state, sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      count       <= '0;
      dropped     <= 1'b0;
      visit_valid <= 1'b0;
    end else begin
      visit_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_HEAD) begin
              head    <= cylinder;
              count   <= '0;
              dropped <= 1'b0;
            end else if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (last) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          lower    <= lower_next;
          up_first <= ({1'b0, count} > {lower_next, 1'b0});
          state    <= S_HEAD;
        end
        S_HEAD: begin
          visit_valid    <= 1'b1;
          visit_cylinder <= head_c;
          total_movement <= '0;
          overflow       <= dropped;
          last_res       <= 1'b0;
          if (up_first) begin
            idx   <= IW'(lower);
            state <= S_ASC;
          end else if (lower != '0) begin
            idx   <= IW'(lower - CW'(1));
            state <= S_DESC;
          end else begin
            state <= S_MID;
          end
        end
        S_ASC: begin
          visit_valid    <= 1'b1;
          visit_cylinder <= rd_clamp;
          total_movement <= '0;
          overflow       <= dropped;
          last_res       <= 1'b0;
          if (CW'(idx) == count - CW'(1)) begin
            state <= up_first ? S_MID : S_FIN;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_MID: begin
          visit_valid    <= 1'b1;
          visit_cylinder <= up_first ? top_c : '0;
          total_movement <= '0;
          overflow       <= dropped;
          last_res       <= 1'b0;
          if (up_first) begin
            if (lower != '0) begin
              idx   <= IW'(lower - CW'(1));
              state <= S_DESC;
            end else begin
              state <= S_FIN;
            end
          end else begin
            if (lower != count) begin
              idx   <= IW'(lower);
              state <= S_ASC;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DESC: begin
          visit_valid    <= 1'b1;
          visit_cylinder <= rd_clamp;
          total_movement <= '0;
          overflow       <= dropped;
          last_res       <= 1'b0;
          if (idx == '0) begin
            state <= up_first ? S_FIN : S_MID;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        S_FIN: begin
          visit_valid    <= 1'b1;
          visit_cylinder <= up_first ? '0 : top_c;
          total_movement <= up_first ? ({top_c, 1'b0} - MOVE_W'(head_c))
                                     : (MOVE_W'(top_c) + MOVE_W'(head_c));
          overflow       <= dropped;
          last_res       <= 1'b1;
          count          <= '0;
          dropped        <= 1'b0;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The final beat of a job always finds the sequencer back at rest.
  `ASSERT_IMPL(a_last_idle, clk, rst, visit_valid && last_res, !busy)
  // The fill count never passes the capacity of the chain.
  `ASSERT_IMPL(a_cnt_cap, clk, rst, 1'b1, count <= CW'(MAX_REQUESTS))
  // A beat marked last starts scheduling.
  `ASSERT_NEXT(a_last_start, clk, rst, start && !busy && last, state == S_PREP)
  // Finishing a job emits the final beat and empties the request store.
  `ASSERT_NEXT(a_fin_out, clk, rst, state == S_FIN, visit_valid && last_res && count == '0)

endmodule

// ===== rtl/sdsch_cell.sv =====
`timescale 1ns / 1ps

module sdsch_cell (
  input  logic                clk,
  input  sdsch_pkg::sdsch_ctl_t ctl,
  input  logic                occ,
  input  logic                prev_keep,
  input  sdsch_pkg::cyl_t     prev_val,
  input  sdsch_pkg::cyl_t     head_c,
  output sdsch_pkg::cyl_t     val,
  output logic                keep,
  output logic                below
);
  import sdsch_pkg::*;

  // An occupied cell whose value does not exceed the new key stays put.
  assign keep  = occ && (val <= ctl.key);

  // Occupied cells under the head form the lower part of the sweep.
  assign below = occ && (val < head_c);

  // The first non-keeping cell takes the key; the ones after it shift along.
  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      val <= prev_keep ? ctl.key : prev_val;
    end
  end

endmodule
